[rtl/wftc_pkg.sv]
// ----------------------------------------------------------------------------
// Wall-follow turn controller package
// Shared types and constants for the turn controller modules.
// ----------------------------------------------------------------------------
package wftc_pkg;

   localparam int DistWidth  = 12;
   localparam int TickWidth  = 8;
   localparam int StrkWidth  = 4;
   localparam int BiasWidth  = 6;
   localparam int CsrIdxWidth = 3;
   localparam int CsrDataWidth = 12;

   // Register indexes on the configuration port.
   localparam logic [CsrIdxWidth-1:0] CSR_WALL_NEAR     = 3'd0;
   localparam logic [CsrIdxWidth-1:0] CSR_FRONT_STOP    = 3'd1;
   localparam logic [CsrIdxWidth-1:0] CSR_BRAKE_TICKS   = 3'd2;
   localparam logic [CsrIdxWidth-1:0] CSR_PIVOT_LIMIT   = 3'd3;
   localparam logic [CsrIdxWidth-1:0] CSR_FRONT_CLEAR   = 3'd4;
   localparam logic [CsrIdxWidth-1:0] CSR_CENTER_TOL    = 3'd5;
   localparam logic [CsrIdxWidth-1:0] CSR_STREAK_NEEDED = 3'd6;
   localparam logic [CsrIdxWidth-1:0] CSR_SIDE_BIAS     = 3'd7;

   // Speed and trim command codes.
   localparam logic [1:0] SPEED_NONE = 2'd0;
   localparam logic [1:0] SPEED_SLOW = 2'd1;
   localparam logic [1:0] SPEED_FAST = 2'd2;
   localparam logic [1:0] TRIM_NONE  = 2'd0;
   localparam logic [1:0] TRIM_UP    = 2'd1;
   localparam logic [1:0] TRIM_DOWN  = 2'd2;

   // Mode codes as they appear on the result port.
   localparam logic [2:0] CODE_STRAIGHT = 3'd0;
   localparam logic [2:0] CODE_BRAKE_R  = 3'd1;
   localparam logic [2:0] CODE_BRAKE_L  = 3'd2;
   localparam logic [2:0] CODE_PIVOT_R  = 3'd3;
   localparam logic [2:0] CODE_PIVOT_L  = 3'd4;

   // Steering dead band on right minus left.
   localparam logic signed [DistWidth:0] STEER_DEAD = 13'sd2;

   typedef enum logic [4:0] {
      MODE_STRAIGHT = 5'b00001,
      MODE_BRAKE_R  = 5'b00010,
      MODE_BRAKE_L  = 5'b00100,
      MODE_PIVOT_R  = 5'b01000,
      MODE_PIVOT_L  = 5'b10000
   } mode_type;

   typedef struct packed {
      logic [DistWidth-1:0]        near_level;
      logic [DistWidth-1:0]        stop_level;
      logic [TickWidth-1:0]        brake_ticks;
      logic [TickWidth-1:0]        pivot_limit_ticks;
      logic [DistWidth-1:0]        clear_level;
      logic [TickWidth-1:0]        center_tolerance_cm;
      logic [StrkWidth-1:0]        center_streak_needed;
      logic signed [BiasWidth-1:0] side_bias_cm;
   } cfg_type;

   typedef struct packed {
      logic [DistWidth-1:0] left_dist;
      logic [DistWidth-1:0] right_dist;
      logic [DistWidth-1:0] front_dist;
   } item_type;

   typedef struct packed {
      mode_type             mode;
      logic [TickWidth-1:0] tick_count;
      logic [StrkWidth-1:0] centered_streak;
      logic                 left_reverse;
      logic                 right_reverse;
   } state_type;

   typedef struct packed {
      logic [1:0] speed_cmd;
      logic [1:0] left_trim;
      logic [1:0] right_trim;
      logic       left_reverse;
      logic       right_reverse;
      logic [2:0] mode_out;
   } result_type;

   function automatic logic [2:0] mode_code(input mode_type m);
      logic [2:0] code;
      unique case (m)
         MODE_BRAKE_R: code = CODE_BRAKE_R;
         MODE_BRAKE_L: code = CODE_BRAKE_L;
         MODE_PIVOT_R: code = CODE_PIVOT_R;
         MODE_PIVOT_L: code = CODE_PIVOT_L;
         default:      code = CODE_STRAIGHT;
      endcase
      return code;
   endfunction

endpackage

[rtl/wftc_csr.sv]
// ----------------------------------------------------------------------------
// Wall-follow turn controller configuration registers
// Holds the eight tuning registers, written through a plain write port.
// ----------------------------------------------------------------------------
module wftc_csr
   import wftc_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_wen,
   input  logic [CsrIdxWidth-1:0]  csr_index,
   input  logic [CsrDataWidth-1:0] csr_wdata,
   output cfg_type                 cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wen) begin
         unique case (csr_index)
            CSR_WALL_NEAR:     cfg_in.near_level           = csr_wdata;
            CSR_FRONT_STOP:    cfg_in.stop_level           = csr_wdata;
            CSR_BRAKE_TICKS:   cfg_in.brake_ticks          = csr_wdata[TickWidth-1:0];
            CSR_PIVOT_LIMIT:   cfg_in.pivot_limit_ticks    = csr_wdata[TickWidth-1:0];
            CSR_FRONT_CLEAR:   cfg_in.clear_level          = csr_wdata;
            CSR_CENTER_TOL:    cfg_in.center_tolerance_cm  = csr_wdata[TickWidth-1:0];
            CSR_STREAK_NEEDED: cfg_in.center_streak_needed = csr_wdata[StrkWidth-1:0];
            CSR_SIDE_BIAS:     cfg_in.side_bias_cm = $signed(csr_wdata[BiasWidth-1:0]);
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.near_level           <= 12'd65;
         cfg_ff.stop_level           <= 12'd50;
         cfg_ff.brake_ticks          <= 8'd12;
         cfg_ff.pivot_limit_ticks    <= 8'd29;
         cfg_ff.clear_level          <= 12'd50;
         cfg_ff.center_tolerance_cm  <= 8'd10;
         cfg_ff.center_streak_needed <= 4'd3;
         cfg_ff.side_bias_cm         <= 6'sd0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

[rtl/wftc_step.sv]
// ----------------------------------------------------------------------------
// Wall-follow turn controller step logic
// Computes the result and the next controller state for one tick.
// ----------------------------------------------------------------------------
module wftc_step
   import wftc_pkg::*;
(
   input  cfg_type    cfg,
   input  state_type  state,
   input  item_type   item,
   output state_type  state_next,
   output result_type result
);

   logic [TickWidth:0]          tick_inc;
   logic [StrkWidth-1:0]        streak_inc;
   logic [StrkWidth-1:0]        streak_new;
   logic signed [DistWidth+1:0] side_diff;
   logic signed [DistWidth+1:0] tol_s;
   logic signed [DistWidth:0]   steer_err;
   logic                        centred;
   logic                        clear;
   logic                        near_any;
   logic                        near_front;

   assign tick_inc   = {1'b0, state.tick_count} + 9'd1;
   assign streak_inc = (state.centered_streak == '1) ? state.centered_streak
                                                      : state.centered_streak + 4'd1;
   assign side_diff  = $signed({2'b00, item.left_dist}) - $signed({2'b00, item.right_dist})
                       - {{(DistWidth+2-BiasWidth){cfg.side_bias_cm[BiasWidth-1]}},
                          cfg.side_bias_cm};
   assign tol_s      = $signed({6'd0, cfg.center_tolerance_cm});
   assign centred    = (side_diff >= -tol_s) && (side_diff <= tol_s);
   assign clear      = item.front_dist >= cfg.clear_level;
   assign streak_new = (centred && clear) ? streak_inc : '0;
   assign steer_err  = $signed({1'b0, item.right_dist}) - $signed({1'b0, item.left_dist});
   assign near_front = item.front_dist <= cfg.near_level;
   assign near_any   = near_front || (item.left_dist <= cfg.near_level)
                       || (item.right_dist <= cfg.near_level);

   always_comb begin
      state_next        = state;
      result.speed_cmd  = SPEED_NONE;
      result.left_trim  = TRIM_NONE;
      result.right_trim = TRIM_NONE;
      unique case (state.mode)
         MODE_BRAKE_R, MODE_BRAKE_L: begin
            result.left_trim      = TRIM_DOWN;
            result.right_trim     = TRIM_DOWN;
            state_next.tick_count = tick_inc[TickWidth-1:0];
            if (tick_inc >= {1'b0, cfg.brake_ticks}) begin
               state_next.tick_count = '0;
               if (state.mode == MODE_BRAKE_R) begin
                  state_next.mode          = MODE_PIVOT_R;
                  state_next.right_reverse = 1'b1;
                  state_next.left_reverse  = 1'b0;
               end else begin
                  state_next.mode          = MODE_PIVOT_L;
                  state_next.right_reverse = 1'b0;
                  state_next.left_reverse  = 1'b1;
               end
            end
         end
         MODE_PIVOT_R, MODE_PIVOT_L: begin
            result.speed_cmd           = near_front ? SPEED_SLOW : SPEED_FAST;
            state_next.centered_streak = streak_new;
            // A full streak ends the pivot before the timeout counter moves.
            if (streak_new >= cfg.center_streak_needed ||
                tick_inc >= {1'b0, cfg.pivot_limit_ticks}) begin
               state_next.mode            = MODE_STRAIGHT;
               state_next.tick_count      = '0;
               state_next.centered_streak = '0;
               state_next.left_reverse    = 1'b0;
               state_next.right_reverse   = 1'b0;
            end else begin
               state_next.tick_count = tick_inc[TickWidth-1:0];
            end
         end
         default: begin
            state_next.mode          = MODE_STRAIGHT;
            state_next.left_reverse  = 1'b0;
            state_next.right_reverse = 1'b0;
            result.speed_cmd         = near_any ? SPEED_SLOW : SPEED_FAST;
            if (steer_err > STEER_DEAD) begin
               result.left_trim  = TRIM_UP;
               result.right_trim = TRIM_DOWN;
            end else if (steer_err < -STEER_DEAD) begin
               result.left_trim  = TRIM_DOWN;
               result.right_trim = TRIM_UP;
            end
            if (item.front_dist <= cfg.stop_level) begin
               state_next.tick_count = '0;
               state_next.mode = (item.right_dist >= item.left_dist) ? MODE_BRAKE_R
                                                                     : MODE_BRAKE_L;
            end
         end
      endcase
      result.left_reverse  = state_next.left_reverse;
      result.right_reverse = state_next.right_reverse;
      result.mode_out      = mode_code(state_next.mode);
   end

endmodule

[rtl/wall_follow_turn_controller.sv]
// ----------------------------------------------------------------------------
// Wall-follow turn controller
// Per-tick steering, braking and pivot control from three distance sensors.
// ----------------------------------------------------------------------------
// Usage: each word on the req_ channel is one control tick with the left,
// right and front distances. For each tick the block returns exactly one
// word on the rsp_ channel with the speed command, both wheel trims, the
// wheel directions and the mode after the tick.
// The tick is first captured in an input register; the step logic then runs
// on it, and the result is captured in the output register as soon as that
// register is free or drains, and is offered on rsp_ until it is taken.
// Throughput is one tick per cycle while the receiver does not stall: the
// controller state is updated at the same edge that loads the output
// register, so the following tick already sees it.
// When the receiver stalls, the output register holds its word and the
// input register may still take one more tick; after that req_stall rises.
// Reset clears the mode to straight, the counters and the wheel directions,
// empties both registers and restores the default tuning registers.
// The user must write tuning registers through csr_ only while no tick is in flight; the block does not enforce this.
// ----------------------------------------------------------------------------
module wall_follow_turn_controller
   import wftc_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_wen,
   input  logic [CsrIdxWidth-1:0]  csr_index,
   input  logic [CsrDataWidth-1:0] csr_wdata,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [DistWidth-1:0]    req_left_dist,
   input  logic [DistWidth-1:0]    req_right_dist,
   input  logic [DistWidth-1:0]    req_front_dist,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [1:0]              rsp_speed_cmd,
   output logic [1:0]              rsp_left_trim,
   output logic [1:0]              rsp_right_trim,
   output logic                    rsp_left_reverse,
   output logic                    rsp_right_reverse,
   output logic [2:0]              rsp_mode_out
);

   cfg_type    cfg;
   logic       in_valid_ff;
   item_type   in_item_ff;
   state_type  state_ff;
   state_type  state_in;
   logic       rsp_valid_ff;
   result_type rsp_ff;
   result_type rsp_in;
   logic       step_go;
   logic       req_take;

   wftc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wen   (csr_wen),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   wftc_step u_step (
      .cfg        (cfg),
      .state      (state_ff),
      .item       (in_item_ff),
      .state_next (state_in),
      .result     (rsp_in)
   );

   // The held tick moves on whenever the output register is free or drains.
   assign step_go   = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !step_go;
   assign req_take  = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= '{mode: MODE_STRAIGHT, tick_count: '0, centered_streak: '0,
                           left_reverse: 1'b0, right_reverse: 1'b0};
      end else begin
         if (req_take) begin
            in_valid_ff <= 1'b1;
         end else if (step_go) begin
            in_valid_ff <= 1'b0;
         end
         if (step_go) begin
            rsp_valid_ff <= 1'b1;
            state_ff     <= state_in;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_item_ff <= '{left_dist: req_left_dist, right_dist: req_right_dist,
                         front_dist: req_front_dist};
      end
      if (step_go) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_speed_cmd     = rsp_ff.speed_cmd;
   assign rsp_left_trim     = rsp_ff.left_trim;
   assign rsp_right_trim    = rsp_ff.right_trim;
   assign rsp_left_reverse  = rsp_ff.left_reverse;
   assign rsp_right_reverse = rsp_ff.right_reverse;
   assign rsp_mode_out      = rsp_ff.mode_out;

endmodule

[rtl/wftc_checker.sv]
// ----------------------------------------------------------------------------
// Wall-follow turn controller checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
module wftc_checker
   import wftc_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [1:0] rsp_speed_cmd,
   input logic [1:0] rsp_left_trim,
   input logic [1:0] rsp_right_trim,
   input logic       rsp_left_reverse,
   input logic       rsp_right_reverse,
   input logic [2:0] rsp_mode_out
);

   // A stalled result word stays in place.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_mode_out)
         && $stable(rsp_speed_cmd) && $stable(rsp_left_trim) && $stable(rsp_right_trim))
      else $error("result word changed while stalled");

   // Only a pivot drives a wheel backward, and only the matching wheel.
   a_rev_mode: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_left_reverse == (rsp_mode_out == CODE_PIVOT_L))
         && (rsp_right_reverse == (rsp_mode_out == CODE_PIVOT_R)))
      else $error("wheel direction disagrees with mode");

   // Mode and command codes stay in their defined ranges.
   a_codes: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_mode_out <= CODE_PIVOT_L) && (rsp_speed_cmd != 2'd3)
         && (rsp_left_trim != 2'd3) && (rsp_right_trim != 2'd3))
      else $error("undefined code on result word");

   // On the tick that ends braking and enters a pivot, the car coasts with both wheels slowed.
   a_brake_cmd: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_mode_out == CODE_PIVOT_R || rsp_mode_out == CODE_PIVOT_L)
         && rsp_left_trim == TRIM_DOWN |-> rsp_speed_cmd == SPEED_NONE
         && rsp_right_trim == TRIM_DOWN)
      else $error("pivot entry without brake commands");

endmodule

bind wall_follow_turn_controller wftc_checker u_wftc_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_speed_cmd     (rsp_speed_cmd),
   .rsp_left_trim     (rsp_left_trim),
   .rsp_right_trim    (rsp_right_trim),
   .rsp_left_reverse  (rsp_left_reverse),
   .rsp_right_reverse (rsp_right_reverse),
   .rsp_mode_out      (rsp_mode_out)
);
